[rtl/macrc_pkg.sv]
package macrc_pkg;

  // Both count tables are indexed by the 12-bit code A2A1A0 B2B1B0 C2C1C0 D2D1D0.
  localparam int unsigned TABLE_AW    = 12;
  localparam int unsigned TABLE_DEPTH = 1 << TABLE_AW;

  localparam int unsigned CFG_W   = 18;
  localparam int unsigned CFG_IW  = 3;
  localparam int unsigned SQ_W    = 15;
  localparam int unsigned ALT_W   = 18;
  localparam int unsigned SEC_W   = 16;
  localparam int unsigned CONF_W  = 8;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_STAT_INTERVAL = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_CONFIRM_COUNT = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_CRUISE_LOW    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_CRUISE_HIGH   = 3'd3;

  localparam logic [SEC_W-1:0]         RST_STAT_INTERVAL = 16'd10;
  localparam logic [CONF_W-1:0]        RST_CONFIRM_COUNT = 8'd3;
  localparam logic signed [ALT_W-1:0]  RST_CRUISE_LOW    = 18'sd16700;
  localparam logic signed [ALT_W-1:0]  RST_CRUISE_HIGH   = 18'sd48900;

  // Emergency squawks: hijack, radio failure, general emergency.
  localparam logic [SQ_W-1:0] SQ_HIJACK    = 15'h7500;
  localparam logic [SQ_W-1:0] SQ_RADIO     = 15'h7600;
  localparam logic [SQ_W-1:0] SQ_EMERGENCY = 15'h7700;
  localparam logic [SQ_W-1:0] SQ_MASK      = 15'h7777;

  localparam logic signed [ALT_W-1:0] GILL_STEP_FT = 18'sd100;
  localparam logic [11:0]             GILL_OFFSET  = 12'd13;

  typedef enum logic [1:0] {
    CLASS_NONE   = 2'd0,
    CLASS_MODE_A = 2'd1,
    CLASS_MODE_C = 2'd2
  } class_t;

  typedef enum logic [1:0] {
    PATH_REJECT,
    PATH_DIRECT_A,
    PATH_SURE,
    PATH_DOUBT
  } path_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    path_t                    path;
    logic [TABLE_AW-1:0]      idx;
    logic [SQ_W-1:0]          sq;
    logic                     spi;
    logic                     gill_ok;
    logic [ALT_W-1:0]         alt;
  } dec_t;

endpackage

[rtl/macrc_table.sv]
module macrc_table import macrc_pkg::*; #(
  parameter int unsigned WIDTH = 17
) (
  input  logic                clk,
  input  logic                we,
  input  logic [TABLE_AW-1:0] waddr,
  input  logic [WIDTH-1:0]    wdata,
  input  logic [TABLE_AW-1:0] raddr,
  output logic [WIDTH-1:0]    rdata_r
);

  logic [WIDTH-1:0] mem_r [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

endmodule

[rtl/macrc_decode.sv]
module macrc_decode import macrc_pkg::*; (
  input  logic       clk,
  input  logic       load_in,
  input  logic       load_dec,
  input  logic [7:0] high_byte,
  input  logic [7:0] low_byte,
  output dec_t       dec_r
);

  logic [7:0]          hi_r;
  logic [7:0]          lo_r;
  logic [14:0]         m;
  logic [SQ_W-1:0]     sq;
  logic [2:0]          cv;
  logic [2:0]          dv;
  logic                reject;
  logic                emerg;
  logic                sure_rule;
  logic [2:0]          one_raw;
  logic [2:0]          one_fix;
  logic [2:0]          one_fin;
  logic [7:0]          five;
  logic [10:0]         five5;
  logic [11:0]         hund;
  logic                gill_ok;
  logic [ALT_W-1:0]    alt;
  dec_t                dec_nxt;

  always_ff @(posedge clk) begin
    if (load_in) begin
      hi_r <= high_byte;
      lo_r <= low_byte;
    end
  end

  // Rearrange the raw reply bits into the ABCD nibble layout.
  always_comb begin
    m      = '0;
    m[4]   = hi_r[4];
    m[12]  = hi_r[3];
    m[5]   = hi_r[2];
    m[13]  = hi_r[1];
    m[6]   = hi_r[0];
    m[7]   = hi_r[7];
    m[14]  = lo_r[7];
    m[8]   = lo_r[5];
    m[0]   = lo_r[4];
    m[9]   = lo_r[3];
    m[1]   = lo_r[2];
    m[10]  = lo_r[1];
    m[2]   = lo_r[0];
  end

  assign sq     = m & SQ_MASK;
  assign cv     = m[6:4];
  assign dv     = m[2:0];
  assign reject = ((hi_r == 8'd0) && (lo_r == 8'd0)) || lo_r[6];
  assign emerg  = (sq == SQ_HIJACK) || (sq == SQ_RADIO) || (sq == SQ_EMERGENCY);
  assign sure_rule = (cv == 3'd0) || (cv == 3'd5) || (cv == 3'd7) ||
                     (dv != 3'd0 && dv != 3'd4);

  // Gillham decode: the C bits give the hundreds digit in reflected code,
  // the D, A and B bits give the five-hundreds count in Gray code.
  always_comb begin
    one_raw = (m[4] ? 3'd7 : 3'd0) ^ (m[5] ? 3'd3 : 3'd0) ^ (m[6] ? 3'd1 : 3'd0);
    one_fix = ((one_raw & 3'd5) == 3'd5) ? (one_raw ^ 3'd2) : one_raw;
    five = (m[1]  ? 8'hFF : 8'h00) ^ (m[2]  ? 8'h7F : 8'h00) ^
           (m[12] ? 8'h3F : 8'h00) ^ (m[13] ? 8'h1F : 8'h00) ^
           (m[14] ? 8'h0F : 8'h00) ^ (m[8]  ? 8'h07 : 8'h00) ^
           (m[9]  ? 8'h03 : 8'h00) ^ (m[10] ? 8'h01 : 8'h00);
    one_fin = five[0] ? (3'd6 - one_fix) : one_fix;
    gill_ok = !(m[0] || m[7]) && (m[7:4] != 4'd0) && (one_fix <= 3'd5);
    five5 = {1'b0, five, 2'b00} + {3'b000, five};
    hund  = {1'b0, five5} + {9'd0, one_fin} - GILL_OFFSET;
    alt   = $signed({{(ALT_W-12){hund[11]}}, hund}) * GILL_STEP_FT;
  end

  always_comb begin
    dec_nxt.idx     = {m[14:12], m[10:8], m[6:4], m[2:0]};
    dec_nxt.sq      = sq;
    dec_nxt.spi     = m[7];
    dec_nxt.gill_ok = gill_ok;
    dec_nxt.alt     = alt;
    priority if (reject) begin
      dec_nxt.path = PATH_REJECT;
    end else if (m[7] || emerg) begin
      dec_nxt.path = PATH_DIRECT_A;
    end else if (sure_rule) begin
      dec_nxt.path = PATH_SURE;
    end else begin
      dec_nxt.path = PATH_DOUBT;
    end
  end

  always_ff @(posedge clk) begin
    if (load_dec) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

[rtl/mode_ac_reply_classifier_unit.sv]
// Mode A/C reply classifier. A word is taken when start is high and busy is low;
// every word gives exactly one result, shown for one cycle with out_valid high,
// and the receiver cannot stall it. A reply word passes through decode, table
// read, decide and write back before the next word can be taken; the table read
// step is there because the two count memories have a registered read port. Its
// result is registered from the decide step. A tick that does not end a statistics
// interval is answered in the next cycle. A tick that ends one starts a commit
// sweep over both 4096-entry tables, one entry per cycle, and holds busy until
// the sweep is done, after which its result appears. After reset the block runs
// a clearing pass over both tables that keeps busy high; configuration writes are
// taken at any time, and should only be made while busy is low and no result is due.
module mode_ac_reply_classifier_unit import macrc_pkg::*; #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_req_type,
  input  logic [7:0]              in_reply_high_byte,
  input  logic [7:0]              in_reply_low_byte,
  output logic                    out_valid,
  output logic [1:0]              out_reply_class,
  output logic [SQ_W-1:0]         out_squawk_code,
  output logic                    out_spi_flag,
  output logic signed [ALT_W-1:0] out_altitude_feet,
  input  logic                    cfg_we,
  input  logic [CFG_IW-1:0]       cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  localparam int unsigned EW    = 2 * COUNT_BITS + 1;
  localparam int unsigned CMP_W = (COUNT_BITS > CONF_W) ? COUNT_BITS : CONF_W;

  state_t                   state_r;
  state_t                   state_nxt;
  logic [TABLE_AW:0]        ptr_r;
  logic                     pend_r;
  logic [TABLE_AW-1:0]      pend_addr_r;
  logic [SEC_W-1:0]         sec_r;
  logic [SEC_W:0]           sec_inc;
  logic                     commit_due;
  logic                     in_accept;
  logic                     tick_accept;
  logic                     reply_accept;

  logic [SEC_W-1:0]         cfg_interval_r;
  logic [CONF_W-1:0]        cfg_confirm_r;
  logic signed [ALT_W-1:0]  cfg_low_r;
  logic signed [ALT_W-1:0]  cfg_high_r;

  dec_t                     dec_r;
  logic [EW-1:0]            sure_rd;
  logic [EW-1:0]            doubt_rd;
  logic                     sure_we;
  logic                     doubt_we;
  logic [TABLE_AW-1:0]      waddr;
  logic [TABLE_AW-1:0]      raddr;
  logic [EW-1:0]            sure_wdata;
  logic [EW-1:0]            doubt_wdata;

  logic                     s_present;
  logic [COUNT_BITS-1:0]    s_comm;
  logic                     d_present;
  logic [COUNT_BITS-1:0]    d_counted;
  logic                     s_trust;
  logic                     d_trust;
  logic                     in_band;
  class_t                   dcd_class;
  logic                     dcd_sure_bump;
  logic                     dcd_doubt_bump;

  logic                     emit;
  class_t                   emit_class;
  logic [SQ_W-1:0]          emit_sq;
  logic                     emit_spi;
  logic [ALT_W-1:0]         emit_alt;

  logic                     out_valid_r;
  class_t                   out_class_r;
  logic [SQ_W-1:0]          out_sq_r;
  logic                     out_spi_r;
  logic [ALT_W-1:0]         out_alt_r;

  // A first sighting starts the entry at one; later sightings count up and saturate.
  function automatic logic [EW-1:0] bump_entry(input logic [EW-1:0] e);
    logic [EW-1:0] r;
    r = e;
    if (!e[EW-1]) begin
      r = {1'b1, {COUNT_BITS{1'b0}}, COUNT_BITS'(1)};
    end else if (!(&e[COUNT_BITS-1:0])) begin
      r[COUNT_BITS-1:0] = e[COUNT_BITS-1:0] + COUNT_BITS'(1);
    end
    return r;
  endfunction

  assign busy         = (state_r != ST_IDLE);
  assign in_accept    = start && !busy;
  assign tick_accept  = in_accept && in_req_type;
  assign reply_accept = in_accept && !in_req_type;
  assign sec_inc      = {1'b0, sec_r} + 17'd1;
  assign commit_due   = (sec_inc >= {1'b0, cfg_interval_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_interval_r <= RST_STAT_INTERVAL;
      cfg_confirm_r  <= RST_CONFIRM_COUNT;
      cfg_low_r      <= RST_CRUISE_LOW;
      cfg_high_r     <= RST_CRUISE_HIGH;
    end else if (cfg_we) begin
      if (cfg_index == CFG_STAT_INTERVAL) begin
        cfg_interval_r <= cfg_wdata[SEC_W-1:0];
      end
      if (cfg_index == CFG_CONFIRM_COUNT) begin
        cfg_confirm_r <= cfg_wdata[CONF_W-1:0];
      end
      if (cfg_index == CFG_CRUISE_LOW) begin
        cfg_low_r <= $signed(cfg_wdata[ALT_W-1:0]);
      end
      if (cfg_index == CFG_CRUISE_HIGH) begin
        cfg_high_r <= $signed(cfg_wdata[ALT_W-1:0]);
      end
    end
  end

  macrc_decode u_decode (
    .clk       (clk),
    .load_in   (reply_accept),
    .load_dec  (state_r == ST_DECODE),
    .high_byte (in_reply_high_byte),
    .low_byte  (in_reply_low_byte),
    .dec_r     (dec_r)
  );

  macrc_table #(.WIDTH(EW)) u_sure (
    .clk     (clk),
    .we      (sure_we),
    .waddr   (waddr),
    .wdata   (sure_wdata),
    .raddr   (raddr),
    .rdata_r (sure_rd)
  );

  macrc_table #(.WIDTH(EW)) u_doubt (
    .clk     (clk),
    .we      (doubt_we),
    .waddr   (waddr),
    .wdata   (doubt_wdata),
    .raddr   (raddr),
    .rdata_r (doubt_rd)
  );

  // Decision on the entry read for the current reply.
  always_comb begin
    s_present = sure_rd[EW-1];
    s_comm    = sure_rd[EW-2:COUNT_BITS];
    d_present = doubt_rd[EW-1];
    d_counted = d_present ? doubt_rd[EW-2:COUNT_BITS] : '0;
    s_trust   = CMP_W'(s_comm) > CMP_W'(cfg_confirm_r);
    d_trust   = CMP_W'(d_counted) > CMP_W'(cfg_confirm_r);
    in_band   = ($signed(dec_r.alt) >= cfg_low_r) && ($signed(dec_r.alt) <= cfg_high_r);
    dcd_class      = CLASS_NONE;
    dcd_sure_bump  = 1'b0;
    dcd_doubt_bump = 1'b0;
    unique case (dec_r.path)
      PATH_REJECT: begin
        dcd_class = CLASS_NONE;
      end
      PATH_DIRECT_A: begin
        dcd_class = CLASS_MODE_A;
      end
      PATH_SURE: begin
        dcd_sure_bump = 1'b1;
        dcd_class     = (!s_present || s_trust) ? CLASS_MODE_A : CLASS_NONE;
      end
      PATH_DOUBT: begin
        if (d_trust) begin
          if (dec_r.gill_ok && in_band) begin
            dcd_class = CLASS_MODE_C;
          end else begin
            dcd_sure_bump = 1'b1;
            dcd_class     = CLASS_MODE_A;
          end
        end else begin
          dcd_doubt_bump = 1'b1;
          dcd_class      = CLASS_NONE;
        end
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (ptr_r[TABLE_AW]) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (reply_accept) begin
          state_nxt = ST_DECODE;
        end else if (tick_accept && commit_due) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_DECODE: state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_IDLE;
      ST_COMMIT: begin
        if (ptr_r[TABLE_AW] && !pend_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    sure_we     = 1'b0;
    doubt_we    = 1'b0;
    waddr       = dec_r.idx;
    raddr       = dec_r.idx;
    sure_wdata  = bump_entry(sure_rd);
    doubt_wdata = bump_entry(doubt_rd);
    emit        = 1'b0;
    emit_class  = CLASS_NONE;
    emit_sq     = '0;
    emit_spi    = 1'b0;
    emit_alt    = '0;
    unique case (state_r)
      ST_CLEAR: begin
        sure_we     = !ptr_r[TABLE_AW];
        doubt_we    = !ptr_r[TABLE_AW];
        waddr       = ptr_r[TABLE_AW-1:0];
        sure_wdata  = '0;
        doubt_wdata = '0;
      end
      ST_IDLE: begin
        emit = tick_accept && !commit_due;
      end
      ST_DECODE, ST_LOOKUP: begin
        emit = 1'b0;
      end
      ST_DECIDE: begin
        sure_we    = dcd_sure_bump;
        doubt_we   = dcd_doubt_bump;
        emit       = 1'b1;
        emit_class = dcd_class;
        if (dcd_class == CLASS_MODE_A) begin
          emit_sq  = dec_r.sq;
          emit_spi = dec_r.spi;
        end
        if (dcd_class == CLASS_MODE_C) begin
          emit_alt = dec_r.alt;
        end
      end
      ST_COMMIT: begin
        // Read one entry per cycle and write the previous one back with its
        // counting value moved into the committed field.
        raddr       = ptr_r[TABLE_AW-1:0];
        waddr       = pend_addr_r;
        sure_we     = pend_r;
        doubt_we    = pend_r;
        sure_wdata  = {sure_rd[EW-1], sure_rd[COUNT_BITS-1:0], {COUNT_BITS{1'b0}}};
        doubt_wdata = {doubt_rd[EW-1], doubt_rd[COUNT_BITS-1:0], {COUNT_BITS{1'b0}}};
        emit        = ptr_r[TABLE_AW] && !pend_r;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      sec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      if (tick_accept) begin
        sec_r <= commit_due ? '0 : sec_inc[SEC_W-1:0];
      end
      if (state_r == ST_CLEAR) begin
        if (!ptr_r[TABLE_AW]) begin
          ptr_r <= ptr_r + {{TABLE_AW{1'b0}}, 1'b1};
        end
      end else if (state_r == ST_COMMIT) begin
        pend_r <= !ptr_r[TABLE_AW];
        if (!ptr_r[TABLE_AW]) begin
          ptr_r <= ptr_r + {{TABLE_AW{1'b0}}, 1'b1};
        end
      end else begin
        ptr_r  <= '0;
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= ptr_r[TABLE_AW-1:0];
    if (emit) begin
      out_class_r <= emit_class;
      out_sq_r    <= emit_sq;
      out_spi_r   <= emit_spi;
      out_alt_r   <= emit_alt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_reply_class   = out_class_r;
  assign out_squawk_code   = out_sq_r;
  assign out_spi_flag      = out_spi_r;
  assign out_altitude_feet = $signed(out_alt_r);

  a_reply_latency: assert property (@(posedge clk) disable iff (!rst_n)
    reply_accept |-> ##4 out_valid)
    else $error("reply word did not produce a result after four cycles");

  a_tick_answer: assert property (@(posedge clk) disable iff (!rst_n)
    tick_accept |=> (out_valid || state_r == ST_COMMIT))
    else $error("tick word neither answered nor started a commit sweep");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while the block is still busy");

  a_commit_no_reply_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECODE || state_r == ST_LOOKUP) |-> !(sure_we || doubt_we))
    else $error("table written before the entry was read");

endmodule
